>>> rtl/inv3_pkg.sv
// inv3_pkg: shared widths, payload structs and cofactor index tables
// for the 3x3 matrix inverse core; depends on nothing
package inv3_pkg;

    // element width is fixed by the payload format
    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS_C  = 16;

    // adjugate entries (difference of two products) and determinant widths
    localparam int ADJ_W = 2 * DATA_WIDTH + 1;
    localparam int DET_W = 3 * DATA_WIDTH + 3;

    // cycles in the front end, in one division lane, and in total
    localparam int FRONT_LAT = 4;
    localparam int LANE_LAT  = DATA_WIDTH + 4;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

    // adj[k] = a[P]*a[Q] - a[R]*a[S], elements in row-major order
    localparam int COF_P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef logic signed [DATA_WIDTH-1:0] elem_t;
    typedef logic signed [ADJ_W-1:0]      adj_t;
    typedef logic signed [DET_W-1:0]      det_t;

    typedef struct packed {
        elem_t a00;
        elem_t a01;
        elem_t a02;
        elem_t a10;
        elem_t a11;
        elem_t a12;
        elem_t a20;
        elem_t a21;
        elem_t a22;
    } mat_t;

    typedef struct packed {
        elem_t inv00;
        elem_t inv01;
        elem_t inv02;
        elem_t inv10;
        elem_t inv11;
        elem_t inv12;
        elem_t inv20;
        elem_t inv21;
        elem_t inv22;
        logic  singular;
    } res_t;

endpackage

>>> rtl/inverse_3x3_matrix_core.sv
// inverse_3x3_matrix_core: top level, front end, nine division lanes and
// the merge/output register; depends on inv3_pkg, inv3_front, inv3_lane
//
// Usage: one 3x3 matrix of signed Q16.16 elements is taken on the mat
// channel (mat_valid/mat_ready) and one result, the rounded and saturated
// inverse plus a singular flag, leaves on the res channel
// (res_valid/res_ready). A singular matrix gives all-zero elements with
// singular set.
// Throughput: one request per cycle while the output is not stalled. The
// latency is set by the one-bit-per-stage division
// pipeline of each lane behind the four-stage cofactor/determinant front.
// Reset clears only the valid bits; no state is kept between requests.
// When res_ready is low with a result waiting, the whole pipeline holds
// and mat_ready falls, even while earlier stages hold bubbles; nothing
// is lost and flow resumes in the cycle res_ready rises again.
module inverse_3x3_matrix_core
    import inv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_C
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic mat_valid,
    output logic mat_ready,
    input  mat_t mat,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    logic  en;
    logic  vld_reg  [TOTAL_LAT];
    logic  sing_reg [LANE_LAT];
    adj_t  adj [9];
    det_t  det;
    elem_t lane_res [9];
    res_t  res_reg;
    res_t  res_next;

    // global pipeline advance
    assign en        = !vld_reg[TOTAL_LAT-1] || res_ready;
    assign mat_ready = en;
    assign res_valid = vld_reg[TOTAL_LAT-1];

    // valid bits follow each request down the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= mat_valid;
            for (int i = 1; i < TOTAL_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    inv3_front u_front (
        .clk (clk),
        .en  (en),
        .mat (mat),
        .adj (adj),
        .det (det)
    );

    // nine lanes, one per inverse element
    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        inv3_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk (clk),
            .en  (en),
            .num (adj[k]),
            .den (det),
            .res (lane_res[k])
        );
    end

    // singular flag travels alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg[0] <= (det == '0);
            for (int i = 1; i < LANE_LAT; i++)
            begin
                sing_reg[i] <= sing_reg[i-1];
            end
        end
    end

    // merge lane results, zeroed when singular
    always_comb
    begin
        res_next          = '0;
        res_next.singular = sing_reg[LANE_LAT-1];
        if (!sing_reg[LANE_LAT-1])
        begin
            res_next.inv00 = lane_res[0];
            res_next.inv01 = lane_res[1];
            res_next.inv02 = lane_res[2];
            res_next.inv10 = lane_res[3];
            res_next.inv11 = lane_res[4];
            res_next.inv12 = lane_res[5];
            res_next.inv20 = lane_res[6];
            res_next.inv21 = lane_res[7];
            res_next.inv22 = lane_res[8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/inv3_front.sv
// inv3_front: cofactor products, adjugate and determinant, four stages
// depends on inv3_pkg
module inv3_front
    import inv3_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  mat_t  mat,
    output adj_t  adj [9],
    output det_t  det
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int HW = DATA_WIDTH + 1;

    elem_t                  am [9];
    logic signed [PW-1:0]   pp_reg [9];
    logic signed [PW-1:0]   pr_reg [9];
    elem_t                  row0_reg [3];
    elem_t                  row1_reg [3];
    adj_t                   adj1_reg [9];
    adj_t                   adj2_reg [9];
    adj_t                   adj3_reg [9];
    logic signed [ADJ_W-1:0] ph_reg [3];
    logic signed [ADJ_W-1:0] pl_reg [3];
    det_t                   det_reg;
    det_t                   det_next;

    // unpack the request into row-major order
    assign am[0] = mat.a00;
    assign am[1] = mat.a01;
    assign am[2] = mat.a02;
    assign am[3] = mat.a10;
    assign am[4] = mat.a11;
    assign am[5] = mat.a12;
    assign am[6] = mat.a20;
    assign am[7] = mat.a21;
    assign am[8] = mat.a22;

    // stages one and two: 2x2 products, then their differences
    for (genvar k = 0; k < 9; k++)
    begin : g_cof
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pp_reg[k]   <= PW'(am[COF_P[k]]) * PW'(am[COF_Q[k]]);
                pr_reg[k]   <= PW'(am[COF_R[k]]) * PW'(am[COF_S[k]]);
                adj1_reg[k] <= ADJ_W'(pp_reg[k]) - ADJ_W'(pr_reg[k]);
                adj2_reg[k] <= adj1_reg[k];
                adj3_reg[k] <= adj2_reg[k];
            end
        end
        assign adj[k] = adj3_reg[k];
    end

    // stage three: first row times first column of the adjugate, split products
    for (genvar j = 0; j < 3; j++)
    begin : g_det
        logic signed [HW-1:0] hi;
        logic signed [HW-1:0] lo;
        assign hi = adj1_reg[3*j][ADJ_W-1:DATA_WIDTH];
        assign lo = {1'b0, adj1_reg[3*j][DATA_WIDTH-1:0]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                row0_reg[j] <= am[j];
                row1_reg[j] <= row0_reg[j];
                ph_reg[j]   <= ADJ_W'(row1_reg[j]) * ADJ_W'(hi);
                pl_reg[j]   <= ADJ_W'(row1_reg[j]) * ADJ_W'(lo);
            end
        end
    end

    // stage four: recombine partial products and sum
    always_comb
    begin
        det_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            det_next = det_next + (DET_W'(ph_reg[j]) <<< DATA_WIDTH) + DET_W'(pl_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= det_next;
        end
    end

    assign det = det_reg;

endmodule

>>> rtl/inv3_lane.sv
// inv3_lane: one element of the inverse, adj * 2^(2F) / det, pipelined
// restoring division one quotient bit per stage; depends on inv3_pkg
module inv3_lane
    import inv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_C
)
(
    input  logic  clk,
    input  logic  en,
    input  adj_t  num,
    input  det_t  den,
    output elem_t res
);

    localparam int QW = DATA_WIDTH + 1;
    localparam int CW = DET_W + DATA_WIDTH + 2;

    logic [ADJ_W-1:0] nmag_reg;
    logic [DET_W-1:0] dmag_reg;
    logic             nega_reg;
    logic [CW-1:0]    r_reg   [DATA_WIDTH+2];
    logic [QW-1:0]    q_reg   [DATA_WIDTH+2];
    logic [DET_W-1:0] d_reg   [DATA_WIDTH+2];
    logic             neg_reg [DATA_WIDTH+2];
    logic             ovf_reg [DATA_WIDTH+2];
    elem_t            res_reg;

    logic [CW-1:0]    rem0;
    logic [CW-1:0]    dtop;
    logic             up;
    logic [QW:0]      qq;
    logic [QW:0]      lim;
    logic [QW:0]      u;
    logic [QW:0]      sres;

    // stage a: magnitudes and result sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= num[ADJ_W-1] ? ADJ_W'(-num) : ADJ_W'(num);
            dmag_reg <= den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
            nega_reg <= num[ADJ_W-1] ^ den[DET_W-1];
        end
    end

    // stage b: scale numerator, catch quotients past the kept bits
    assign rem0 = CW'(nmag_reg) << (2 * FRAC_BITS);
    assign dtop = CW'(dmag_reg) << QW;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= rem0;
            q_reg[0]   <= '0;
            d_reg[0]   <= dmag_reg;
            neg_reg[0] <= nega_reg;
            ovf_reg[0] <= (rem0 >= dtop);
        end
    end

    // division stages, most significant quotient bit first
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int B = DATA_WIDTH - k;
        logic [CW:0] diff;
        assign diff = {1'b0, r_reg[k]} - ((CW + 1)'(d_reg[k]) << B);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k+1]   <= diff[CW] ? r_reg[k] : diff[CW-1:0];
                q_reg[k+1]   <= q_reg[k] | (QW'(!diff[CW]) << B);
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // rounding half away from zero, then saturation
    always_comb
    begin
        up   = ({r_reg[QW], 1'b0} >= (CW + 1)'(d_reg[QW]));
        qq   = (QW + 1)'(q_reg[QW]) + (QW + 1)'(up);
        lim  = neg_reg[QW] ? ((QW + 1)'(1) << (DATA_WIDTH - 1))
                           : ((QW + 1)'(1) << (DATA_WIDTH - 1)) - (QW + 1)'(1);
        u    = (ovf_reg[QW] || (qq > lim)) ? lim : qq;
        sres = neg_reg[QW] ? -u : u;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= sres[DATA_WIDTH-1:0];
        end
    end

    assign res = res_reg;

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking testbench for the 3x3 matrix inverse core
// depends on inv3_pkg and inverse_3x3_matrix_core; drives directed and random matrices
`timescale 1ns / 100ps

module tb_top;
    import inv3_pkg::*;

    typedef logic signed [255:0] wide_t;
    localparam int ONE_Q = 1 << 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic mat_valid = 1'b0;
    logic mat_ready;
    mat_t mat = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    mat_t pending_q[$];
    bit   drain_q[$];
    res_t inverse_q[$];
    int   mismatches = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    int   sent = 0;
    bit   no_idle = 1'b0;

    inverse_3x3_matrix_core dut (
        .clk(clk), .rst_n(rst_n),
        .mat_valid(mat_valid), .mat_ready(mat_ready), .mat(mat),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    // clock
    always #6 clk = ~clk;

    // element k of a matrix in row-major order
    function automatic elem_t elem_of(mat_t m, int k);
        return m[32*(8-k) +: 32];
    endfunction

    function automatic elem_t out_of(res_t r, int k);
        return r[1+32*(8-k) +: 32];
    endfunction

    // cofactor, one term: e[p]*e[q] - e[r]*e[s]
    function automatic wide_t cof(wide_t e[9], int p, int q, int r, int s);
        return e[p] * e[q] - e[r] * e[s];
    endfunction

    // rounded and saturated inverse by the adjugate
    function automatic res_t inverse_of(mat_t m);
        wide_t e[9];
        wide_t adj[9];
        wide_t det;
        logic [255:0] dmag, num, quo, rem, lim;
        bit neg;
        res_t r;
        for (int k = 0; k < 9; k++)
            e[k] = wide_t'(elem_of(m, k));
        adj[0] = cof(e, 4, 8, 5, 7);
        adj[1] = cof(e, 2, 7, 1, 8);
        adj[2] = cof(e, 1, 5, 2, 4);
        adj[3] = cof(e, 5, 6, 3, 8);
        adj[4] = cof(e, 0, 8, 2, 6);
        adj[5] = cof(e, 2, 3, 0, 5);
        adj[6] = cof(e, 3, 7, 4, 6);
        adj[7] = cof(e, 1, 6, 0, 7);
        adj[8] = cof(e, 0, 4, 1, 3);
        det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        r = '0;
        if (det == 0)
        begin
            r.singular = 1'b1;
            return r;
        end
        dmag = det < 0 ? -det : det;
        for (int k = 0; k < 9; k++)
        begin
            neg = (adj[k] < 0) != (det < 0);
            num = (adj[k] < 0 ? -adj[k] : adj[k]) << 32;
            quo = num / dmag;
            rem = num % dmag;
            if (2 * rem >= dmag)
                quo = quo + 1;
            lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
            if (quo > lim)
                quo = lim;
            if (neg)
                quo = -quo;
            r[1+32*(8-k) +: 32] = quo[31:0];
        end
        return r;
    endfunction

    function automatic mat_t mk(int v[9]);
        mat_t m;
        for (int k = 0; k < 9; k++)
            m[32*(8-k) +: 32] = v[k];
        return m;
    endfunction

    function automatic int rnd_small();
        return int'($urandom_range(0, 1 << 20)) - (1 << 19);
    endfunction

    task automatic queue_mat(mat_t m, bit drain);
        pending_q.push_back(m);
        drain_q.push_back(drain);
    endtask

    task automatic report(string what, int k, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch %s field %0d: got %h want %h", what, k, got, want);
    endtask

    // stimulus: directed corner cases then random matrices
    initial
    begin
        int v[9];
        int kind;
        mat_t m;
        queue_mat(mk('{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q}), 1'b0);
        queue_mat(mk('{0, 0, 0, 0, 0, 0, 0, 0, 0}), 1'b0);
        queue_mat('1, 1'b0);
        queue_mat(mk('{32'h7fffffff, 0, 0, 0, 32'h7fffffff, 0, 0, 0, 32'h7fffffff}), 1'b0);
        queue_mat(mk('{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000}), 1'b0);
        queue_mat(mk('{32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0,
                       0, 0, 32'h80000000}), 1'b0);
        queue_mat(mk('{1, 0, 0, 0, 1, 0, 0, 0, 1}), 1'b0);
        queue_mat(mk('{-1, 0, 0, 0, 1, 0, 0, 0, -1}), 1'b0);
        queue_mat(mk('{3 * ONE_Q, 0, 0, 0, -3 * ONE_Q, 0, 0, 0, 7 * ONE_Q}), 1'b0);
        // exact halves: inverse elements of one half in magnitude, no remainder to round
        queue_mat(mk('{1 << 17, 0, 0, 0, -(1 << 17), 0, 0, 0, 1 << 17}), 1'b0);
        queue_mat(mk('{1 << 31, 0, 0, 0, 1 << 31, 0, 0, 0, 1 << 31}), 1'b0);
        queue_mat(mk('{2 * ONE_Q, ONE_Q, 0, ONE_Q, 2 * ONE_Q, ONE_Q, 0, ONE_Q, 2 * ONE_Q}),
                  1'b0);
        queue_mat(mk('{ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q, 6 * ONE_Q,
                       7 * ONE_Q, 8 * ONE_Q, 9 * ONE_Q}), 1'b0);
        queue_mat(mk('{0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 0}), 1'b0);
        queue_mat(mk('{0, 0, -ONE_Q, 0, ONE_Q, 0, -ONE_Q, 0, 0}), 1'b0);
        queue_mat(mk('{32'h7fffffff, 32'h80000000, 1, 1, 32'h7fffffff, 32'h80000000,
                       32'h80000000, 1, 32'h7fffffff}), 1'b0);
        queue_mat(mk('{5, 3, 1, 2, 7, 4, 1, 1, 9}), 1'b0);
        queue_mat(mk('{ONE_Q, ONE_Q, ONE_Q, 0, 0, 0, 5, 6, 7}), 1'b0);
        for (int i = 0; i < 850; i++)
        begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++)
                v[k] = (kind < 3) ? int'($urandom) : rnd_small();
            // diagonal entries moved 8.0 further away from zero
            if (kind >= 3 && kind < 6)
                for (int k = 0; k < 3; k++)
                    v[4*k] = v[4*k] + ((v[4*k] < 0) ? -(8 * ONE_Q) : (8 * ONE_Q));
            // singular: repeated row, zero column or scaled row
            if (kind == 7)
                for (int k = 0; k < 3; k++)
                    v[6+k] = v[k];
            if (kind == 8)
                for (int k = 0; k < 3; k++)
                    v[3*k+1] = 0;
            if (kind == 9)
                for (int k = 0; k < 3; k++)
                    v[3+k] = -2 * v[k];
            m = mk(v);
            queue_mat(m, (i == 0) || (i % 300 == 299));
        end
    end

    // reset
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        bit next_valid;
        if (!rst_n)
        begin
            mat_valid <= 1'b0;
        end
        else if (!(mat_valid && !mat_ready))
        begin
            next_valid = 1'b0;
            if (mat_valid)
            begin
                inverse_q.push_back(inverse_of(mat));
                sent++;
                if (sent % 120 == 0)
                    no_idle = ~no_idle;
                send_gap = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (send_gap > 0)
                send_gap--;
            else if (pending_q.size() > 0 &&
                     !(drain_q[0] && (inverse_q.size() > 0 || mat_valid)))
            begin
                mat <= pending_q.pop_front();
                void'(drain_q.pop_front());
                next_valid = 1'b1;
            end
            mat_valid <= next_valid;
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    report("unexpected result", 0, out_of(res, 0), '0);
                end
                else
                begin
                    want = inverse_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (out_of(res, k) !== out_of(want, k))
                            report("element", k, out_of(res, k), out_of(want, k));
                    if (res.singular !== want.singular)
                        report("singular", 9, res.singular, want.singular);
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 11);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // end of run
    initial
    begin
        wait (rst_n);
        wait (pending_q.size() == 0 && !mat_valid && inverse_q.size() == 0);
        repeat (TOTAL_LAT + 20) @(posedge clk);
        if (mismatches == 0 && inverse_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

endmodule
